// File: src/scl_pkg.sv
// Shared types and constants of the source code lexer.
// No dependencies.
package scl_pkg;

	localparam int unsigned MAX_SOURCE = 1048576;
	localparam int unsigned POS_W      = 21;
	localparam int unsigned KIND_W     = 6;
	localparam logic [POS_W-1:0] LINE_SAT = 21'd1048576;

	// scan modes
	localparam logic [3:0] M_IDLE    = 4'd0;
	localparam logic [3:0] M_INT     = 4'd1;
	localparam logic [3:0] M_DOT     = 4'd2;
	localparam logic [3:0] M_FRAC    = 4'd3;
	localparam logic [3:0] M_IDENT   = 4'd4;
	localparam logic [3:0] M_STR     = 4'd5;
	localparam logic [3:0] M_COMMENT = 4'd6;
	localparam logic [3:0] M_OP      = 4'd7;

	// token kinds
	localparam logic [5:0] T_IF = 6'd0, T_ELSE = 6'd1, T_WHILE = 6'd2, T_FOR = 6'd3;
	localparam logic [5:0] T_RETURN = 6'd4, T_FUNCTION = 6'd5, T_TRUE = 6'd6;
	localparam logic [5:0] T_FALSE = 6'd7, T_NULL = 6'd8, T_INT = 6'd9, T_FLOAT = 6'd10;
	localparam logic [5:0] T_DOUBLE = 6'd11, T_BOOL = 6'd12, T_CHAR = 6'd13;
	localparam logic [5:0] T_EOF = 6'd14, T_NUMBER = 6'd15, T_IDENT = 6'd16;
	localparam logic [5:0] T_STRING = 6'd17, T_LPAREN = 6'd18, T_RPAREN = 6'd19;
	localparam logic [5:0] T_LBRACE = 6'd20, T_RBRACE = 6'd21, T_LBRACK = 6'd22;
	localparam logic [5:0] T_RBRACK = 6'd23, T_COMMA = 6'd24, T_DOT = 6'd25;
	localparam logic [5:0] T_SEMI = 6'd26, T_INC = 6'd27, T_ADD_EQ = 6'd28, T_PLUS = 6'd29;
	localparam logic [5:0] T_DEC = 6'd30, T_SUB_EQ = 6'd31, T_MINUS = 6'd32;
	localparam logic [5:0] T_MUL_EQ = 6'd33, T_STAR = 6'd34, T_DIV_EQ = 6'd35;
	localparam logic [5:0] T_SLASH = 6'd36, T_PERCENT = 6'd37, T_EQ_EQ = 6'd38;
	localparam logic [5:0] T_ASSIGN = 6'd39, T_NOT_EQ = 6'd40, T_BANG = 6'd41;
	localparam logic [5:0] T_LE = 6'd42, T_LT = 6'd43, T_GE = 6'd44, T_GT = 6'd45;
	localparam logic [5:0] T_AND_AND = 6'd46, T_ERROR = 6'd47, T_OR_OR = 6'd48;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [POS_W-1:0]  start;
		logic [POS_W-1:0]  len;
		logic [POS_W-1:0]  line;
		logic              last;
	} token_t;

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic [5:0] op_alone(input logic [7:0] c);
		case (c)
			"+": return T_PLUS;
			"-": return T_MINUS;
			"*": return T_STAR;
			"/": return T_SLASH;
			"=": return T_ASSIGN;
			"!": return T_BANG;
			"<": return T_LT;
			">": return T_GT;
			default: return T_ERROR;
		endcase
	endfunction

	// two-character operator; T_IF (zero) when the pair is none
	function automatic logic [5:0] op_pair(input logic [7:0] c, input logic [7:0] b);
		logic [5:0] k;
		k = T_IF;
		if (b == "=") begin
			case (c)
				"+": k = T_ADD_EQ;
				"-": k = T_SUB_EQ;
				"*": k = T_MUL_EQ;
				"/": k = T_DIV_EQ;
				"=": k = T_EQ_EQ;
				"!": k = T_NOT_EQ;
				"<": k = T_LE;
				">": k = T_GE;
				default: k = T_IF;
			endcase
		end else if (c == "+" && b == "+") k = T_INC;
		else if (c == "-" && b == "-") k = T_DEC;
		else if (c == "&" && b == "&") k = T_AND_AND;
		else if (c == "|" && b == "|") k = T_OR_OR;
		return k;
	endfunction

	// prefix byte 0 is the first character; len saturates at 9
	function automatic logic [5:0] kw_kind(input logic [7:0][7:0] p, input logic [3:0] len);
		logic [63:0] r;
		logic [5:0]  k;
		r = {p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7]};
		k = T_IDENT;
		case (len)
			4'd2: if (r == {"if", 48'd0}) k = T_IF;
			4'd3: begin
				if (r == {"for", 40'd0}) k = T_FOR;
				else if (r == {"int", 40'd0}) k = T_INT;
			end
			4'd4: begin
				if (r == {"else", 32'd0}) k = T_ELSE;
				else if (r == {"true", 32'd0}) k = T_TRUE;
				else if (r == {"null", 32'd0}) k = T_NULL;
				else if (r == {"bool", 32'd0}) k = T_BOOL;
				else if (r == {"char", 32'd0}) k = T_CHAR;
			end
			4'd5: begin
				if (r == {"while", 24'd0}) k = T_WHILE;
				else if (r == {"false", 24'd0}) k = T_FALSE;
				else if (r == {"float", 24'd0}) k = T_FLOAT;
			end
			4'd6: begin
				if (r == {"return", 16'd0}) k = T_RETURN;
				else if (r == {"double", 16'd0}) k = T_DOUBLE;
			end
			4'd8: if (r == "function") k = T_FUNCTION;
			default: k = T_IDENT;
		endcase
		return k;
	endfunction

endpackage

// File: src/source_code_lexer_top.sv
// Streaming lexer top level: scanner state machine and token queue.
// Depends on scl_pkg.
//
//  channel | signals                                      | dir
//  --------+----------------------------------------------+-----
//  in      | in_valid, in_ready, kind, source_byte        | in
//  out     | out_valid, out_ready, token_kind, token_start,| out
//          | token_length, line_number, last_of_run       |
//
// One input byte is scanned per cycle while in_ready is high; it yields zero to
// three tokens, which are written together into an 8-entry token queue. Tokens
// leave the queue one per cycle while out_ready is high, so the sustained rate is
// one byte per cycle while tokens average at most one per byte.
// in_ready drops only when the queue has fewer than three free entries.
// Reset (arst_n low) returns the scanner to idle, line 1, offset 0, empty queue.
module source_code_lexer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [7:0]  source_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  token_kind,
	output logic [20:0] token_start,
	output logic [20:0] token_length,
	output logic [20:0] line_number,
	output logic        last_of_run
);

	localparam int unsigned DEPTH = 8;

	// scanner state
	logic [3:0]       mode_q;
	logic [7:0]       pend_q;
	logic [20:0]      lstart_q;
	logic [20:0]      pos_q;
	logic [20:0]      line_q;
	logic [7:0][7:0]  prefix_q;
	logic [3:0]       idlen_q;
	logic             ended_q;

	// token queue
	scl_pkg::token_t  fifo_q [DEPTH];
	logic [2:0]       wr_q, rd_q;
	logic [3:0]       cnt_q;

	logic accept, pop;
	assign in_ready  = cnt_q <= 4'(DEPTH - 3);
	assign accept    = in_valid && in_ready;
	assign out_valid = cnt_q != 4'd0;
	assign pop       = out_valid && out_ready;

	// next-state and emitted tokens of the accepted item
	logic [3:0]       mode_d;
	logic [7:0]       pend_d;
	logic [20:0]      lstart_d, pos_d, line_d;
	logic [7:0][7:0]  prefix_d;
	logic [3:0]       idlen_d;
	logic             ended_d;
	logic [5:0]       ek [3];
	logic [20:0]      es [3];
	logic [20:0]      el [3];
	logic [1:0]       n;
	logic             do_idle;
	logic [7:0]       c;
	logic [20:0]      p;
	logic [5:0]       kp;

	always_comb begin
		mode_d   = mode_q;
		pend_d   = pend_q;
		lstart_d = lstart_q;
		pos_d    = pos_q;
		line_d   = line_q;
		prefix_d = prefix_q;
		idlen_d  = idlen_q;
		ended_d  = ended_q;
		n        = 2'd0;
		do_idle  = 1'b0;
		c        = source_byte;
		p        = pos_q;
		kp       = scl_pkg::op_pair(pend_q, source_byte);
		for (int i = 0; i < 3; i++) begin
			ek[i] = scl_pkg::T_EOF;
			es[i] = '0;
			el[i] = '0;
		end
		if (ended_q) begin
			// everything after end of source is dropped
		end else if (kind) begin
			unique case (mode_q) inside
				scl_pkg::M_INT, scl_pkg::M_FRAC: begin
					ek[n] = scl_pkg::T_NUMBER; es[n] = lstart_q; el[n] = p - lstart_q;
					n = n + 2'd1;
				end
				scl_pkg::M_DOT: begin
					ek[n] = scl_pkg::T_NUMBER; es[n] = lstart_q;
					el[n] = p - 21'd1 - lstart_q;
					n = n + 2'd1;
					ek[n] = scl_pkg::T_DOT; es[n] = p - 21'd1; el[n] = 21'd1;
					n = n + 2'd1;
				end
				scl_pkg::M_IDENT: begin
					ek[n] = (idlen_q <= 4'd8) ? scl_pkg::kw_kind(prefix_q, idlen_q)
					                          : scl_pkg::T_IDENT;
					es[n] = lstart_q; el[n] = p - lstart_q;
					n = n + 2'd1;
				end
				scl_pkg::M_OP: begin
					ek[n] = scl_pkg::op_alone(pend_q); es[n] = lstart_q; el[n] = 21'd1;
					n = n + 2'd1;
				end
				default: ;
			endcase
			ek[n] = scl_pkg::T_EOF; es[n] = p; el[n] = '0;
			n = n + 2'd1;
			mode_d  = scl_pkg::M_IDLE;
			ended_d = 1'b1;
		end else if (32'(pos_q) < scl_pkg::MAX_SOURCE) begin
			pos_d = pos_q + 21'd1;
			unique case (mode_q) inside
				scl_pkg::M_INT, scl_pkg::M_FRAC: begin
					if (scl_pkg::is_digit(c)) ;
					else if (c == "." && mode_q == scl_pkg::M_INT) mode_d = scl_pkg::M_DOT;
					else begin
						ek[n] = scl_pkg::T_NUMBER; es[n] = lstart_q; el[n] = p - lstart_q;
						n = n + 2'd1;
						do_idle = 1'b1;
					end
				end
				scl_pkg::M_DOT: begin
					if (scl_pkg::is_digit(c)) mode_d = scl_pkg::M_FRAC;
					else begin
						ek[n] = scl_pkg::T_NUMBER; es[n] = lstart_q;
						el[n] = p - 21'd1 - lstart_q;
						n = n + 2'd1;
						ek[n] = scl_pkg::T_DOT; es[n] = p - 21'd1; el[n] = 21'd1;
						n = n + 2'd1;
						do_idle = 1'b1;
					end
				end
				scl_pkg::M_IDENT: begin
					if (scl_pkg::is_alpha(c) || scl_pkg::is_digit(c)) begin
						if (idlen_q < 4'd8) prefix_d[idlen_q[2:0]] = c;
						if (idlen_q < 4'd9) idlen_d = idlen_q + 4'd1;
					end else begin
						ek[n] = (idlen_q <= 4'd8) ? scl_pkg::kw_kind(prefix_q, idlen_q)
						                          : scl_pkg::T_IDENT;
						es[n] = lstart_q; el[n] = p - lstart_q;
						n = n + 2'd1;
						do_idle = 1'b1;
					end
				end
				scl_pkg::M_STR: begin
					if (c == "\"") begin
						ek[n] = scl_pkg::T_STRING; es[n] = lstart_q; el[n] = p - lstart_q;
						n = n + 2'd1;
						mode_d = scl_pkg::M_IDLE;
					end else if (c == "\n" && line_q < scl_pkg::LINE_SAT) begin
						line_d = line_q + 21'd1;
					end
				end
				scl_pkg::M_COMMENT: begin
					if (c == "\n") do_idle = 1'b1;
				end
				scl_pkg::M_OP: begin
					if (pend_q == "/" && c == "/") mode_d = scl_pkg::M_COMMENT;
					else if (kp != scl_pkg::T_IF) begin
						ek[n] = kp; es[n] = lstart_q; el[n] = 21'd2;
						n = n + 2'd1;
						mode_d = scl_pkg::M_IDLE;
					end else begin
						ek[n] = scl_pkg::op_alone(pend_q); es[n] = lstart_q; el[n] = 21'd1;
						n = n + 2'd1;
						do_idle = 1'b1;
					end
				end
				default: do_idle = 1'b1;
			endcase
			// byte seen from idle: single-character tokens, whitespace and newlines, or start of a lexeme
			if (do_idle) begin
				mode_d = scl_pkg::M_IDLE;
				es[n]  = p;
				el[n]  = 21'd1;
				case (c) inside
					"(": begin ek[n] = scl_pkg::T_LPAREN;  n = n + 2'd1; end
					")": begin ek[n] = scl_pkg::T_RPAREN;  n = n + 2'd1; end
					"{": begin ek[n] = scl_pkg::T_LBRACE;  n = n + 2'd1; end
					"}": begin ek[n] = scl_pkg::T_RBRACE;  n = n + 2'd1; end
					"[": begin ek[n] = scl_pkg::T_LBRACK;  n = n + 2'd1; end
					"]": begin ek[n] = scl_pkg::T_RBRACK;  n = n + 2'd1; end
					",": begin ek[n] = scl_pkg::T_COMMA;   n = n + 2'd1; end
					".": begin ek[n] = scl_pkg::T_DOT;     n = n + 2'd1; end
					";": begin ek[n] = scl_pkg::T_SEMI;    n = n + 2'd1; end
					"%": begin ek[n] = scl_pkg::T_PERCENT; n = n + 2'd1; end
					"+", "-", "*", "/", "=", "!", "<", ">", "&", "|": begin
						mode_d = scl_pkg::M_OP; pend_d = c; lstart_d = p;
					end
					" ", "\r", "\t": ;
					"\n": if (line_q < scl_pkg::LINE_SAT) line_d = line_q + 21'd1;
					"\"": begin mode_d = scl_pkg::M_STR; lstart_d = p + 21'd1; end
					default: begin
						if (scl_pkg::is_digit(c)) begin
							mode_d = scl_pkg::M_INT; lstart_d = p;
						end else if (scl_pkg::is_alpha(c)) begin
							mode_d = scl_pkg::M_IDENT; lstart_d = p;
							prefix_d = 64'(c); idlen_d = 4'd1;
						end else begin
							ek[n] = scl_pkg::T_ERROR; n = n + 2'd1;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= scl_pkg::M_IDLE;
			pend_q   <= '0;
			lstart_q <= '0;
			pos_q    <= '0;
			line_q   <= 21'd1;
			prefix_q <= '0;
			idlen_q  <= '0;
			ended_q  <= 1'b0;
		end else if (accept) begin
			mode_q   <= mode_d;
			pend_q   <= pend_d;
			lstart_q <= lstart_d;
			pos_q    <= pos_d;
			line_q   <= line_d;
			prefix_q <= prefix_d;
			idlen_q  <= idlen_d;
			ended_q  <= ended_d;
		end
	end

	// queue pointers
	logic [1:0] nw;
	assign nw = accept ? n : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + 3'(nw);
			rd_q  <= rd_q + 3'(pop);
			cnt_q <= cnt_q + 4'(nw) - 4'(pop);
		end
	end

	// token payload storage; line is the count before this byte's newline
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (2'(i) < nw)
				fifo_q[wr_q + 3'(i)] <= '{kind: ek[i], start: es[i], len: el[i],
				                          line: line_q, last: (2'(i) == nw - 2'd1)};
		end
	end

	assign token_kind   = fifo_q[rd_q].kind;
	assign token_start  = fifo_q[rd_q].start;
	assign token_length = fifo_q[rd_q].len;
	assign line_number  = fifo_q[rd_q].line;
	assign last_of_run  = fifo_q[rd_q].last;

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 4'(DEPTH)) else $error("token queue overflow");
	a_ended_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ended_q |=> ended_q) else $error("end flag cleared");
	a_quiet_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ended_q) |-> n == 2'd0) else $error("token after end");
	a_eof_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind && !ended_q) |-> n != 2'd0) else $error("end without token");
`endif

endmodule

// File: tb/sv/source_code_lexer_sb.sv
// Token scoreboard for the source code lexer: predicts tokens from each byte
// transfer and checks them in order. Depends on scl_pkg.
package source_code_lexer_sb_pkg;

	class lexer_scoreboard;
		scl_pkg::token_t tokens_due[$];
		scl_pkg::token_t step_toks[$];
		int           errors;
		int           checked;
		logic [3:0]   mode;
		logic [7:0]   held;
		logic [20:0]  lex_start;
		logic [20:0]  pos;
		logic [20:0]  line;
		logic [7:0]   prefix[8];
		int           id_len;
		bit           done;
		string        keywords[14] = '{"if", "else", "while", "for", "return", "function",
			"true", "false", "null", "int", "float", "double", "bool", "char"};

		function new();
			mode = scl_pkg::M_IDLE;
			held = 8'd0;
			lex_start = '0;
			pos = '0;
			line = 21'd1;
			id_len = 0;
			done = 0;
			errors = 0;
			checked = 0;
		endfunction

		function void put(logic [5:0] k, logic [20:0] s, logic [20:0] l);
			scl_pkg::token_t t;
			if (step_toks.size() >= 4)
				return;
			t.kind = k;
			t.start = s;
			t.len = l;
			t.line = line;
			t.last = 1'b0;
			step_toks.push_back(t);
		endfunction

		function bit digit(logic [7:0] c);
			return c >= "0" && c <= "9";
		endfunction

		function bit letter(logic [7:0] c);
			return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
		endfunction

		function void next_line();
			if (line < scl_pkg::LINE_SAT)
				line++;
		endfunction

		function logic [5:0] lone_op(logic [7:0] c);
			case (c)
				"+": return scl_pkg::T_PLUS;
				"-": return scl_pkg::T_MINUS;
				"*": return scl_pkg::T_STAR;
				"/": return scl_pkg::T_SLASH;
				"=": return scl_pkg::T_ASSIGN;
				"!": return scl_pkg::T_BANG;
				"<": return scl_pkg::T_LT;
				">": return scl_pkg::T_GT;
				default: return scl_pkg::T_ERROR;
			endcase
		endfunction

		// returns T_ERROR when the two bytes form no operator
		function logic [5:0] two_char_op(logic [7:0] c, logic [7:0] b);
			if (b == "=") begin
				case (c)
					"+": return scl_pkg::T_ADD_EQ;
					"-": return scl_pkg::T_SUB_EQ;
					"*": return scl_pkg::T_MUL_EQ;
					"/": return scl_pkg::T_DIV_EQ;
					"=": return scl_pkg::T_EQ_EQ;
					"!": return scl_pkg::T_NOT_EQ;
					"<": return scl_pkg::T_LE;
					">": return scl_pkg::T_GE;
					default: return scl_pkg::T_ERROR;
				endcase
			end
			if (c == "+" && b == "+") return scl_pkg::T_INC;
			if (c == "-" && b == "-") return scl_pkg::T_DEC;
			if (c == "&" && b == "&") return scl_pkg::T_AND_AND;
			if (c == "|" && b == "|") return scl_pkg::T_OR_OR;
			return scl_pkg::T_ERROR;
		endfunction

		function void close_ident(logic [20:0] stop);
			logic [5:0] k;
			string      word;
			k = scl_pkg::T_IDENT;
			if (id_len <= 8) begin
				word = "";
				for (int i = 0; i < id_len; i++)
					word = {word, string'(prefix[i])};
				for (int i = 0; i < 14; i++)
					if (word == keywords[i])
						k = 6'(i);
			end
			put(k, lex_start, stop - lex_start);
		endfunction

		function void from_idle(logic [7:0] c, logic [20:0] p);
			mode = scl_pkg::M_IDLE;
			case (c) inside
				"(": put(scl_pkg::T_LPAREN, p, 1);
				")": put(scl_pkg::T_RPAREN, p, 1);
				"{": put(scl_pkg::T_LBRACE, p, 1);
				"}": put(scl_pkg::T_RBRACE, p, 1);
				"[": put(scl_pkg::T_LBRACK, p, 1);
				"]": put(scl_pkg::T_RBRACK, p, 1);
				",": put(scl_pkg::T_COMMA, p, 1);
				".": put(scl_pkg::T_DOT, p, 1);
				";": put(scl_pkg::T_SEMI, p, 1);
				"%": put(scl_pkg::T_PERCENT, p, 1);
				"+", "-", "*", "/", "=", "!", "<", ">", "&", "|": begin
					mode = scl_pkg::M_OP;
					held = c;
					lex_start = p;
				end
				" ", 8'h0d, 8'h09: ;
				8'h0a: next_line();
				"\"": begin
					mode = scl_pkg::M_STR;
					lex_start = p + 1;
				end
				default: begin
					if (digit(c)) begin
						mode = scl_pkg::M_INT;
						lex_start = p;
					end else if (letter(c)) begin
						mode = scl_pkg::M_IDENT;
						lex_start = p;
						prefix[0] = c;
						id_len = 1;
					end else
						put(scl_pkg::T_ERROR, p, 1);
				end
			endcase
		endfunction

		// one accepted input transfer
		function void note_input(logic is_end, logic [7:0] c);
			logic [20:0] p;
			logic [5:0]  k;
			p = pos;
			step_toks.delete();
			if (done)
				return;
			if (is_end) begin
				case (mode) inside
					scl_pkg::M_INT, scl_pkg::M_FRAC:
						put(scl_pkg::T_NUMBER, lex_start, p - lex_start);
					scl_pkg::M_DOT: begin
						put(scl_pkg::T_NUMBER, lex_start, p - 1 - lex_start);
						put(scl_pkg::T_DOT, p - 1, 1);
					end
					scl_pkg::M_IDENT: close_ident(p);
					scl_pkg::M_OP: put(lone_op(held), lex_start, 1);
					default: ;
				endcase
				put(scl_pkg::T_EOF, p, 0);
				mode = scl_pkg::M_IDLE;
				done = 1;
			end else begin
				if (p >= scl_pkg::MAX_SOURCE)
					return;
				case (mode)
					scl_pkg::M_INT: begin
						if (c == ".")
							mode = scl_pkg::M_DOT;
						else if (!digit(c)) begin
							put(scl_pkg::T_NUMBER, lex_start, p - lex_start);
							from_idle(c, p);
						end
					end
					scl_pkg::M_DOT: begin
						if (digit(c))
							mode = scl_pkg::M_FRAC;
						else begin
							put(scl_pkg::T_NUMBER, lex_start, p - 1 - lex_start);
							put(scl_pkg::T_DOT, p - 1, 1);
							from_idle(c, p);
						end
					end
					scl_pkg::M_FRAC: begin
						if (!digit(c)) begin
							put(scl_pkg::T_NUMBER, lex_start, p - lex_start);
							from_idle(c, p);
						end
					end
					scl_pkg::M_IDENT: begin
						if (letter(c) || digit(c)) begin
							if (id_len < 8)
								prefix[id_len] = c;
							if (id_len < 9)
								id_len++;
						end else begin
							close_ident(p);
							from_idle(c, p);
						end
					end
					scl_pkg::M_STR: begin
						if (c == "\"") begin
							put(scl_pkg::T_STRING, lex_start, p - lex_start);
							mode = scl_pkg::M_IDLE;
						end else if (c == 8'h0a)
							next_line();
					end
					scl_pkg::M_COMMENT: begin
						if (c == 8'h0a)
							from_idle(c, p);
					end
					scl_pkg::M_OP: begin
						k = two_char_op(held, c);
						if (held == "/" && c == "/")
							mode = scl_pkg::M_COMMENT;
						else if (k != scl_pkg::T_ERROR) begin
							put(k, lex_start, 2);
							mode = scl_pkg::M_IDLE;
						end else begin
							put(lone_op(held), lex_start, 1);
							from_idle(c, p);
						end
					end
					default: from_idle(c, p);
				endcase
				pos = p + 1;
			end
			if (step_toks.size() > 0)
				step_toks[step_toks.size() - 1].last = 1'b1;
			foreach (step_toks[i])
				tokens_due.push_back(step_toks[i]);
		endfunction

		function void check_token(scl_pkg::token_t got);
			scl_pkg::token_t want;
			checked++;
			if (tokens_due.size() == 0) begin
				$error("unexpected token kind %0d start %0d", got.kind, got.start);
				errors++;
				return;
			end
			want = tokens_due.pop_front();
			if (got.kind != want.kind) begin
				$error("token_kind expected %0d actual %0d", want.kind, got.kind);
				errors++;
			end
			if (got.start != want.start) begin
				$error("token_start expected %0d actual %0d", want.start, got.start);
				errors++;
			end
			if (got.len != want.len) begin
				$error("token_length expected %0d actual %0d", want.len, got.len);
				errors++;
			end
			if (got.line != want.line) begin
				$error("line_number expected %0d actual %0d", want.line, got.line);
				errors++;
			end
			if (got.last != want.last) begin
				$error("last_of_run expected %0d actual %0d", want.last, got.last);
				errors++;
			end
		endfunction
	endclass
endpackage

// File: tb/sv/testbench.sv
// Top-level testbench of source_code_lexer_top: drives byte transfers made of
// directed and random source fragments and checks every token. Depends on scl_pkg and
// source_code_lexer_sb_pkg.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT = 60000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b1;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        kind = 1'b0;
	logic [7:0]  source_byte = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [5:0]  token_kind;
	logic [20:0] token_start;
	logic [20:0] token_length;
	logic [20:0] line_number;
	logic        last_of_run;

	source_code_lexer_sb_pkg::lexer_scoreboard sb = new();
	int          cycles = 0;
	int          bytes_sent = 0;
	logic [7:0]  frag[$];

	source_code_lexer_top i_dut (.*);

	always #4 clk = ~clk;

	// Quiet windows: no idling on the input for bytes 150..249, and the
	// output never stalls between cycles 1500 and 2300.
	function automatic bit in_gap();
		return !(bytes_sent >= 150 && bytes_sent < 250) && $urandom_range(99) < 9;
	endfunction

	// Output side: check on every transfer, then pick next ready.
	always @(posedge clk) begin
		scl_pkg::token_t got;
		cycles++;
		if (cycles > LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
		if (arst_n && out_valid && out_ready) begin
			got.kind = token_kind;
			got.start = token_start;
			got.len = token_length;
			got.line = line_number;
			got.last = last_of_run;
			sb.check_token(got);
		end
		out_ready <= (cycles >= 1500 && cycles < 2300) ? 1'b1 : ($urandom_range(99) >= 9);
	end

	// One input transfer. Valid stays high across back-to-back items; it only
	// drops for one cycle when a random gap is taken.
	task automatic send(logic is_end, logic [7:0] b);
		if (in_gap()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= is_end;
		source_byte <= b;
		do @(posedge clk); while (!in_ready);
		sb.note_input(is_end, b);
		bytes_sent++;
	endtask

	task automatic send_frag();
		while (frag.size() > 0)
			send(1'b0, frag.pop_front());
	endtask

	function automatic logic [7:0] alnum();
		case ($urandom_range(2))
			0: return 8'($urandom_range("z", "a"));
			1: return 8'($urandom_range("9", "0"));
			default: return ($urandom_range(3) == 0) ? "_" : 8'($urandom_range("Z", "A"));
		endcase
	endfunction

	// Builds one random lexeme (plus, sometimes, a trailing separator) into frag.
	function automatic void make_frag();
		string ops = "+-*/=!<>&|";
		string puncts = "(){}[],.;%";
		string ws = " \t\r\n";
		string w;
		int    n;
		case ($urandom_range(9)) inside
			0, 1: begin
				// keyword, sometimes cut short or extended
				w = sb.keywords[$urandom_range(13)];
				n = w.len();
				if ($urandom_range(4) == 0)
					n = $urandom_range(w.len(), 1);
				for (int i = 0; i < n; i++)
					frag.push_back(w[i]);
				if ($urandom_range(4) == 0)
					frag.push_back(alnum());
			end
			2: begin
				frag.push_back(8'($urandom_range("z", "a")));
				n = $urandom_range(11);
				repeat (n) frag.push_back(alnum());
			end
			3: begin
				repeat ($urandom_range(4, 1)) frag.push_back(8'($urandom_range("9", "0")));
				if ($urandom_range(1)) begin
					frag.push_back(".");
					repeat ($urandom_range(3)) frag.push_back(8'($urandom_range("9", "0")));
				end
			end
			4: begin
				frag.push_back("\"");
				repeat ($urandom_range(5))
					frag.push_back(($urandom_range(7) == 0) ? 8'h0a : alnum());
				frag.push_back("\"");
			end
			5: begin
				frag.push_back(ops[$urandom_range(9)]);
				if ($urandom_range(2) != 0)
					frag.push_back(($urandom_range(1)) ? "=" : ops[$urandom_range(9)]);
			end
			6: begin
				frag.push_back("/");
				frag.push_back("/");
				repeat ($urandom_range(4)) frag.push_back(alnum());
				frag.push_back(8'h0a);
			end
			7: frag.push_back(puncts[$urandom_range(9)]);
			8: frag.push_back(8'($urandom_range(255)));
			default: frag.push_back(ws[$urandom_range(3)]);
		endcase
		if ($urandom_range(2) == 0)
			frag.push_back(ws[$urandom_range(3)]);
	endfunction

	initial begin
		string directed;
		int    tail;
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: fraction, dot after a number, string, comment, lone & and |,
		// NUL and top byte, long identifier that starts like a keyword.
		directed = "9.5;3.x\"q\"//c\n&|";
		for (int i = 0; i < directed.len(); i++)
			frag.push_back(directed[i]);
		frag.push_back(8'h00);
		frag.push_back(8'hff);
		directed = "functions if ";
		for (int i = 0; i < directed.len(); i++)
			frag.push_back(directed[i]);
		send_frag();

		while (bytes_sent < 455) begin
			make_frag();
			send_frag();
		end

		// End of source with something still open: a number with a held dot,
		// an unterminated string, or an open comment.
		tail = $urandom_range(2);
		case (tail)
			0: begin frag.push_back("7"); frag.push_back("."); end
			1: begin frag.push_back("\""); frag.push_back("a"); end
			default: begin frag.push_back("/"); frag.push_back("/"); end
		endcase
		send_frag();
		send(1'b1, 8'($urandom_range(255)));
		// after the end everything is ignored
		repeat (3) send(1'($urandom_range(1)), 8'($urandom_range(255)));
		in_valid <= 1'b0;

		while (sb.tokens_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Fed %0d input transfers of mixed source text ending in a flush;",
			bytes_sent);
		$display("checked %0d tokens field by field.", sb.checked);
		if (sb.errors == 0 && sb.tokens_due.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
